@@ rtl/core/pfi_pkg.sv @@
package pfi_pkg;

   localparam int COUNT_W       = 10;
   localparam int VALUE_W       = 11;
   localparam int LEN_W         = 11;
   localparam int LEN_RESET     = 1024;
   localparam int DEFAULT_MAX_N = 1024;
   localparam int EPOCH_W       = 8;

   typedef struct packed {
      logic accept;
      logic step;
      logic finish;
      logic sweep;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic last_level;
      logic wrap;
      logic sweep_done;
   } status_type;

endpackage

@@ rtl/core/pfi_if.sv @@
interface pfi_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfi_pkg::COUNT_W-1:0] greater_count;

   modport source (output valid, output greater_count, input ready);
   modport sink   (input valid, input greater_count, output ready);
endinterface

interface pfi_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pfi_pkg::VALUE_W-1:0] value;
   logic                        invalid;
   logic                        last;

   modport source (output valid, output value, output invalid, output last, input ready);
   modport sink   (input valid, input value, input invalid, input last, output ready);
endinterface

@@ rtl/core/pfi_ctrl.sv @@
module pfi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output pfi_pkg::cmd_type     cmd,
   input  pfi_pkg::status_type  status
);
   import pfi_pkg::*;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.invalid) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (status.last_level) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
      // a refill or length write that runs out of epochs needs a fresh sweep
      if (status.wrap) begin
         state_in = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/pfi_dpath.sv @@
module pfi_dpath #(
   parameter int MAX_N = pfi_pkg::DEFAULT_MAX_N
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [pfi_pkg::LEN_W-1:0]   csr_wdata,
   input  logic [pfi_pkg::COUNT_W-1:0] req_greater_count,
   input  pfi_pkg::cmd_type            cmd,
   output pfi_pkg::status_type         status,
   output logic [pfi_pkg::VALUE_W-1:0] rsp_value,
   output logic                        rsp_invalid,
   output logic                        rsp_last
);
   import pfi_pkg::*;

   localparam int LOG   = $clog2(MAX_N);
   localparam int TW    = LOG + 1;
   localparam int AW    = LOG + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int MW    = EPOCH_W + TW;
   localparam int N_RST = (LEN_RESET > MAX_N) ? MAX_N : LEN_RESET;

   logic [MW-1:0]      mem [DEPTH];

   logic [TW-1:0]      n_ff, n_in;
   logic [TW-1:0]      remaining_ff, remaining_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [AW-1:0]      sweep_addr_ff, sweep_addr_in;
   logic               invalid_ff, invalid_in;
   logic [TW-1:0]      k_ff, k_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [TW-1:0]      lo_ff, lo_in;
   logic [TW-1:0]      size_ff, size_in;
   logic [MW-1:0]      rd_l_ff, rd_r_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               out_invalid_ff, out_last_ff;

   logic [TW-1:0]      n_eff, half, lsum, rsum, chosen_sum;
   logic               go_left, advance, wrap;
   logic [AW-1:0]      chosen, rd_base;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [MW-1:0]      mem_wdata;

   // free count of a node: stored value if written this epoch, else the full-tree value
   function automatic logic [TW-1:0] node_count(input logic [MW-1:0] word,
                                                input logic [EPOCH_W-1:0] epoch,
                                                input logic [TW-1:0] n,
                                                input logic [TW-1:0] lo,
                                                input logic [TW-1:0] sz);
      logic [TW-1:0] diff;
      logic [TW-1:0] res;
      diff = n - lo;
      if (word[MW-1 -: EPOCH_W] == epoch) begin
         res = word[TW-1:0];
      end else if (n <= lo) begin
         res = '0;
      end else if (diff >= sz) begin
         res = sz;
      end else begin
         res = diff;
      end
      return res;
   endfunction

   always_comb begin
      if (csr_wdata == '0) begin
         n_eff = TW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_N)) begin
         n_eff = TW'(MAX_N);
      end else begin
         n_eff = TW'(csr_wdata);
      end
   end

   assign half       = size_ff >> 1;
   assign lsum       = node_count(rd_l_ff, epoch_ff, n_ff, lo_ff, half);
   assign rsum       = node_count(rd_r_ff, epoch_ff, n_ff, lo_ff + half, half);
   assign go_left    = (k_ff <= lsum);
   assign chosen     = {idx_ff[AW-2:0], !go_left};
   assign chosen_sum = go_left ? lsum : rsum;
   assign rd_base    = cmd.step ? chosen : AW'(1);

   assign advance = csr_we ||
                    (cmd.finish && !invalid_ff && (remaining_ff == TW'(1)));
   assign wrap    = advance && (epoch_ff == '1);

   assign status.invalid    = invalid_ff;
   assign status.last_level = (size_ff == TW'(2));
   assign status.wrap       = wrap;
   assign status.sweep_done = (sweep_addr_ff == '1);

   assign mem_we    = cmd.step || cmd.sweep;
   assign mem_waddr = cmd.step ? chosen : sweep_addr_ff;
   assign mem_wdata = cmd.step ? {epoch_ff, chosen_sum - TW'(1)} : '0;

   always_comb begin
      n_in          = n_ff;
      remaining_in  = remaining_ff;
      epoch_in      = epoch_ff;
      sweep_addr_in = sweep_addr_ff;
      invalid_in    = invalid_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      size_in       = size_ff;

      if (cmd.sweep) begin
         sweep_addr_in = sweep_addr_ff + AW'(1);
      end
      if (cmd.accept) begin
         invalid_in = (32'(req_greater_count) >= 32'(remaining_ff));
         k_in       = remaining_ff - TW'(req_greater_count);
         idx_in     = AW'(1);
         lo_in      = '0;
         size_in    = TW'(2 ** LOG);
      end
      if (cmd.step) begin
         idx_in  = chosen;
         size_in = half;
         if (!go_left) begin
            lo_in = lo_ff + half;
            k_in  = k_ff - lsum;
         end
      end
      if (cmd.finish && !invalid_ff) begin
         if (remaining_ff == TW'(1)) begin
            remaining_in = n_ff;
         end else begin
            remaining_in = remaining_ff - TW'(1);
         end
      end
      if (csr_we) begin
         n_in         = n_eff;
         remaining_in = n_eff;
      end
      if (advance) begin
         epoch_in = epoch_ff + EPOCH_W'(1);
      end
      if (wrap) begin
         epoch_in      = EPOCH_W'(1);
         sweep_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff          <= TW'(N_RST);
         remaining_ff  <= TW'(N_RST);
         epoch_ff      <= EPOCH_W'(1);
         sweep_addr_ff <= '0;
         invalid_ff    <= 1'b0;
      end else begin
         n_ff          <= n_in;
         remaining_ff  <= remaining_in;
         epoch_ff      <= epoch_in;
         sweep_addr_ff <= sweep_addr_in;
         invalid_ff    <= invalid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      lo_ff   <= lo_in;
      size_ff <= size_in;
      if (cmd.finish) begin
         out_invalid_ff <= invalid_ff;
         value_ff       <= invalid_ff ? '0 : VALUE_W'(lo_ff + TW'(1));
         out_last_ff    <= !invalid_ff && (remaining_ff == TW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_l_ff <= mem[{rd_base[AW-2:0], 1'b0}];
      rd_r_ff <= mem[{rd_base[AW-2:0], 1'b1}];
   end

   assign rsp_value   = value_ff;
   assign rsp_invalid = out_invalid_ff;
   assign rsp_last    = out_last_ff;

endmodule

@@ rtl/core/permutation_from_inversions_core.sv @@
// Channel | Dir | Handshake       | Payload
// req_bus | in  | valid / ready   | greater_count[9:0]
// rsp_bus | out | valid / ready   | value[10:0], invalid, last
// csr     | in  | csr_we, no wait | csr_wdata[10:0] = perm_length
//
// An item is accepted, then takes a read-modify-write of the node memory for each
// of the log2(MAX_N) tree levels, then its result is loaded. An out-of-range count
// is flagged without a tree step. A new item is taken while a result waits.
// After reset, and on every 255th refill or length write, a sweep clears all
// 2 * 2^log2(MAX_N) node words (2048 at default); no item is taken during the sweep.
// A stalled result holds the block in its final cycle until rsp_bus.ready.
module permutation_from_inversions_core #(
   parameter int MAX_N = pfi_pkg::DEFAULT_MAX_N
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [pfi_pkg::LEN_W-1:0] csr_wdata,
   pfi_req_if.sink                   req_bus,
   pfi_rsp_if.source                 rsp_bus
);
   import pfi_pkg::*;

   cmd_type    cmd;
   status_type status;

   pfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd),
      .status    (status)
   );

   pfi_dpath #(
      .MAX_N (MAX_N)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_greater_count (req_bus.greater_count),
      .cmd               (cmd),
      .status            (status),
      .rsp_value         (rsp_bus.value),
      .rsp_invalid       (rsp_bus.invalid),
      .rsp_last          (rsp_bus.last)
   );

endmodule
